// ===== rtl/core/fsrm_pkg.sv =====
package fsrm_pkg;

    // Payload widths
    localparam int PIX_W     = 8;
    localparam int SUM_W     = 20;
    localparam int IDX_OUT_W = 5;
    localparam int PLOT_W    = 8;

    // Saturation limit of a column accumulator
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Configuration registers
    localparam int FC_W       = 6;
    localparam int FB_W       = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [FC_W-1:0] FC_RESET = FC_W'(20);
    localparam logic [FB_W-1:0] FB_RESET = FB_W'(4096);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_COUNT = 1'b0,
        CFG_FRAME_BYTES = 1'b1
    } t_cfg_idx;

endpackage

// ===== rtl/core/fsrm_sad_alu.sv =====
module fsrm_sad_alu
    import fsrm_pkg::*;
(
    input  logic [PIX_W-1:0] i_pix,
    input  logic [PIX_W-1:0] i_ref,
    input  logic [SUM_W-1:0] i_sum,
    output logic [SUM_W-1:0] o_sum
);

    logic [PIX_W-1:0] abs_diff;
    logic [SUM_W:0]   raw_sum;

    // Absolute byte difference
    assign abs_diff = (i_pix > i_ref) ? (i_pix - i_ref) : (i_ref - i_pix);

    // Accumulate and saturate at the top of the sum range
    assign raw_sum = {1'b0, i_sum} + (SUM_W + 1)'(abs_diff);
    assign o_sum   = raw_sum[SUM_W] ? SUM_MAX : raw_sum[SUM_W-1:0];

endmodule

// ===== rtl/core/frame_sad_recurrence_matrix.sv =====
// Per byte of frame k: accept, k reads of earlier frames through the shared difference
// unit and the single frame store read port, then writeback; input stalls meanwhile.
// Frame end: a read and a load step per emitted entry, k + 1 entries for frame k; loads wait on output stall.
// The last result may still sit in the output register when the next byte is taken.
// Reset (synchronous, active low) clears position, frame index, accumulator valid bits and
// control registers; the frame store, accumulator array and output data are not cleared.
module frame_sad_recurrence_matrix
    import fsrm_pkg::*;
#(
    parameter int MAX_FRAMES      = 32,
    parameter int MAX_FRAME_BYTES = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PIX_W-1:0]      i_pixel_byte,
    // Output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [IDX_OUT_W-1:0]  o_row_index,
    output logic [IDX_OUT_W-1:0]  o_column_index,
    output logic [SUM_W-1:0]      o_sad_sum,
    output logic [PLOT_W-1:0]     o_plot_byte,
    output logic                  o_last_in_row
);

    localparam int AW  = $clog2(MAX_FRAMES);
    localparam int CW  = $clog2(MAX_FRAMES + 1);
    localparam int PW  = $clog2(MAX_FRAME_BYTES);
    localparam int EBW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CBW = (EBW > FB_W) ? EBW : FB_W;
    localparam int CCW = (CW > FC_W) ? CW : FC_W;
    localparam int STORE_DEPTH = MAX_FRAMES * (2 ** PW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_WB,
        S_ERD,
        S_ELD
    } t_state;

    t_state r_state;

    logic [FC_W-1:0]  r_frame_count;
    logic [FB_W-1:0]  r_frame_bytes;
    logic [CW-1:0]    r_cur;
    logic [PW-1:0]    r_pos;
    logic [AW-1:0]    r_j;
    logic [PIX_W-1:0] r_pix;
    logic             r_frame_end;

    logic [PIX_W-1:0] r_store [STORE_DEPTH];
    logic [PIX_W-1:0] r_store_q;

    logic [SUM_W-1:0]      r_sums [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] r_sum_vld;
    logic [SUM_W-1:0]      r_sum_q;
    logic                  r_sum_qv;
    logic                  r_wb_en;
    logic [AW-1:0]         r_wb_j;

    logic                 r_out_valid;
    logic [IDX_OUT_W-1:0] r_row_index;
    logic [IDX_OUT_W-1:0] r_column_index;
    logic [SUM_W-1:0]     r_sad_sum;
    logic                 r_last_in_row;

    logic [CBW-1:0]   fb_ext;
    logic [CBW-1:0]   eff_bytes_w;
    logic [EBW-1:0]   eff_bytes;
    logic [CCW-1:0]   fc_ext;
    logic [CCW-1:0]   eff_count;
    logic [AW-1:0]    cur_idx;
    logic             active;
    logic             in_beat;
    logic             frame_end;
    logic             out_free;
    logic             j_is_cur;
    logic             row_done;
    logic             rd_en;
    logic [SUM_W-1:0] prior_sum;
    logic [SUM_W-1:0] new_sum;
    logic [SUM_W-1:0] entry_sum;

    // Clamp the configuration to the supported range
    assign fb_ext      = CBW'(r_frame_bytes);
    assign eff_bytes_w = (fb_ext == '0) ? CBW'(1) :
                         (fb_ext > CBW'(MAX_FRAME_BYTES)) ? CBW'(MAX_FRAME_BYTES) : fb_ext;
    assign eff_bytes   = EBW'(eff_bytes_w);
    assign fc_ext      = CCW'(r_frame_count);
    assign eff_count   = (fc_ext == '0) ? CCW'(1) :
                         (fc_ext > CCW'(MAX_FRAMES)) ? CCW'(MAX_FRAMES) : fc_ext;

    // Intake control
    assign cur_idx    = AW'(r_cur);
    assign active     = CCW'(r_cur) < eff_count;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_beat    = i_in_valid && !o_in_stall;
    assign frame_end  = ((EBW + 1)'(r_pos) + (EBW + 1)'(1)) >= (EBW + 1)'(eff_bytes);

    // Emit control
    assign out_free = !r_out_valid || !i_out_stall;
    assign j_is_cur = (r_j == cur_idx);
    assign row_done = (r_state == S_ELD) && out_free && j_is_cur;
    assign rd_en    = (r_state == S_ACC) || (r_state == S_ERD);

    // Shared difference and accumulate unit
    assign prior_sum = r_sum_qv ? r_sum_q : '0;

    fsrm_sad_alu u_alu (
        .i_pix (r_pix),
        .i_ref (r_store_q),
        .i_sum (prior_sum),
        .o_sum (new_sum)
    );

    assign entry_sum = j_is_cur ? '0 : prior_sum;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= FC_RESET;
            r_frame_bytes <= FB_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_COUNT: r_frame_count <= i_cfg_data[FC_W-1:0];
                CFG_FRAME_BYTES: r_frame_bytes <= i_cfg_data[FB_W-1:0];
            endcase
        end
    end

    // Frame store: write the accepted byte, read one earlier frame per cycle while accumulating
    always_ff @(posedge i_clk) begin
        if (in_beat && active) begin
            r_store[{cur_idx, r_pos}] <= i_pixel_byte;
        end
        if (r_state == S_ACC) begin
            r_store_q <= r_store[{r_j, r_pos}];
        end
    end

    // Column accumulators: at most one read and one writeback per cycle
    always_ff @(posedge i_clk) begin
        if (r_wb_en) begin
            r_sums[r_wb_j] <= new_sum;
        end
        if (rd_en) begin
            r_sum_q <= r_sums[r_j];
        end
    end

    // Sequencer, accumulator valid bits and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_pos       <= '0;
            r_j         <= '0;
            r_frame_end <= 1'b0;
            r_sum_vld   <= '0;
            r_sum_qv    <= 1'b0;
            r_wb_en     <= 1'b0;
            r_wb_j      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_wb_en <= (r_state == S_ACC);
            r_wb_j  <= r_j;

            if (rd_en) begin
                r_sum_qv <= r_sum_vld[r_j];
            end
            if (r_wb_en) begin
                r_sum_vld[r_wb_j] <= 1'b1;
            end

            // Load an output beat from the emit step, drop it once taken
            if ((r_state == S_ELD) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_beat && active) begin
                        r_pix       <= i_pixel_byte;
                        r_frame_end <= frame_end;
                        r_j         <= '0;
                        r_state     <= (r_cur == '0) ? S_WB : S_ACC;
                    end
                end
                S_ACC: begin
                    // Issue one earlier frame per cycle
                    if (r_j == cur_idx - AW'(1)) begin
                        r_state <= S_WB;
                    end else begin
                        r_j <= r_j + AW'(1);
                    end
                end
                S_WB: begin
                    // Last writeback lands here; advance position or start the row
                    if (r_frame_end) begin
                        r_j     <= '0;
                        r_state <= S_ERD;
                    end else begin
                        r_pos   <= r_pos + PW'(1);
                        r_state <= S_IDLE;
                    end
                end
                S_ERD: begin
                    r_state <= S_ELD;
                end
                S_ELD: begin
                    if (out_free) begin
                        r_row_index    <= IDX_OUT_W'(r_cur);
                        r_column_index <= IDX_OUT_W'(r_j);
                        r_sad_sum      <= entry_sum;
                        r_last_in_row  <= j_is_cur;
                        if (j_is_cur) begin
                            r_pos     <= '0;
                            r_cur     <= r_cur + CW'(1);
                            r_sum_vld <= '0;
                            r_state   <= S_IDLE;
                        end else begin
                            r_j     <= r_j + AW'(1);
                            r_state <= S_ERD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_row_index    = r_row_index;
    assign o_column_index = r_column_index;
    assign o_sad_sum      = r_sad_sum;
    assign o_plot_byte    = r_sad_sum[PLOT_W-1:0];
    assign o_last_in_row  = r_last_in_row;

    // Writebacks only touch earlier frames
    a_wb_earlier: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_en |-> (r_wb_j < cur_idx))
        else $error("accumulator writeback at or past current frame");

    a_acc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> (r_j < cur_idx))
        else $error("accumulate step beyond current frame");

    a_row_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        row_done |=> (r_sum_vld == '0))
        else $error("accumulators not cleared after row");

    a_diag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_in_row) |-> (o_sad_sum == '0))
        else $error("diagonal entry not zero");

    a_diag_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_in_row) |-> (o_column_index == o_row_index))
        else $error("row end off the diagonal");

endmodule
